// ----- rtl/core/entity_id_allocator_dense_map_macros.svh -----
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ENTITY_ID_ALLOCATOR_DENSE_MAP_MACROS_SVH
`define ENTITY_ID_ALLOCATOR_DENSE_MAP_MACROS_SVH

`define EIDA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed in same cycle");

`define EIDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed in next cycle");

`endif

// ----- rtl/core/eida_pkg.sv -----
`timescale 1ns / 1ps

package eida_pkg;

  localparam int DEFAULT_MAX_IDS = 64;

  localparam logic ACT_ALLOC  = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_DEAD = 2'd2;

  typedef struct packed {
    logic       action;
    logic [5:0] target_id;
  } op_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] entity_out;
    logic [5:0] dense_slot;
    logic [5:0] moved_entity;
    logic       moved_valid;
    logic [6:0] live_total;
  } res_word_t;

  typedef struct packed {
    logic load;
    logic s2i_sel_last;
    logic alloc_commit;
    logic rm_commit;
    logic emit_full;
    logic emit_dead;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_remove;
    logic full;
    logic rm_bad;
    logic live_ok;
  } dp_status_t;

endpackage

// ----- rtl/core/eida_ctrl.sv -----
`timescale 1ns / 1ps

module eida_ctrl
  import eida_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_ALLOC  = 6'b000100,
    ST_LOOKUP = 6'b001000,
    ST_CHECK  = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat.is_remove) begin
          if (stat.rm_bad) begin
            cmd.emit_dead = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_LOOKUP;
          end
        end else begin
          if (stat.full) begin
            cmd.emit_full = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_ALLOC;
          end
        end
      end
      ST_ALLOC: begin
        cmd.alloc_commit = 1'b1;
        state_next       = ST_IDLE;
      end
      ST_LOOKUP: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.live_ok) begin
          cmd.s2i_sel_last = 1'b1;
          state_next       = ST_COMMIT;
        end else begin
          cmd.emit_dead = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_COMMIT: begin
        cmd.rm_commit = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/eida_datapath.sv -----
`timescale 1ns / 1ps

module eida_datapath
  import eida_pkg::*;
#(
  parameter int MAX_IDS = DEFAULT_MAX_IDS
) (
  input  logic       clk,
  input  logic       rst,
  input  op_word_t   op,
  input  ctrl_cmd_t  cmd,
  output dp_status_t stat,
  output logic       done,
  output res_word_t  result
);

  localparam int IW = $clog2(MAX_IDS);
  localparam int CW = $clog2(MAX_IDS + 1);
  localparam logic [31:0] MaxIds32 = 32'(MAX_IDS);
  localparam logic [IW-1:0] LastIdx = IW'(MAX_IDS - 1);
  localparam logic [CW-1:0] FullCount = CW'(MAX_IDS);

  logic          act;
  logic [5:0]    tgt;
  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic          wrapped;
  logic [CW-1:0] count;
  logic [IW-1:0] fr_q;
  bit   [IW-1:0] i2s_q;
  bit   [IW-1:0] s2i_q;

  logic [IW-1:0] free_ring [MAX_IDS];
  bit   [IW-1:0] id_to_slot [MAX_IDS];
  bit   [IW-1:0] slot_to_id [MAX_IDS];

  logic [31:0]   tgt_w;
  logic [IW-1:0] tgt_idx;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] count_dec;
  logic [IW-1:0] count_idx;
  logic [IW-1:0] last;
  logic [IW-1:0] s2i_addr;
  logic [IW-1:0] ring_val;
  logic          moved;
  logic [31:0]   ring_w;
  logic [31:0]   i2s_w;
  logic [31:0]   s2i_w;
  logic [31:0]   cnt_w;
  logic [31:0]   inc_w;
  logic [31:0]   dec_w;

  assign tgt_w     = 32'(tgt);
  assign tgt_idx   = tgt_w[IW-1:0];
  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);
  assign count_idx = count[IW-1:0];
  assign last      = count_dec[IW-1:0];
  assign s2i_addr  = cmd.s2i_sel_last ? last : i2s_q;
  assign ring_val  = (wrapped || (head < tail)) ? fr_q : head;
  assign moved     = (i2s_q != last);

  assign ring_w = 32'(ring_val);
  assign i2s_w  = 32'(i2s_q);
  assign s2i_w  = 32'(s2i_q);
  assign cnt_w  = 32'(count);
  assign inc_w  = 32'(count_inc);
  assign dec_w  = 32'(count_dec);

  assign stat.is_remove = (act == ACT_REMOVE);
  assign stat.full      = (count == FullCount);
  assign stat.rm_bad    = (tgt_w >= MaxIds32) || (count == '0);
  assign stat.live_ok   = (CW'(i2s_q) < count) && (s2i_q == tgt_idx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= op.action;
      tgt <= op.target_id;
    end
  end

  always_ff @(posedge clk) begin
    fr_q <= free_ring[head];
    if (cmd.rm_commit) begin
      free_ring[tail] <= tgt_idx;
    end
  end

  always_ff @(posedge clk) begin
    i2s_q <= id_to_slot[tgt_idx];
    if (cmd.alloc_commit) begin
      id_to_slot[ring_val] <= count_idx;
    end else if (cmd.rm_commit && moved) begin
      id_to_slot[s2i_q] <= i2s_q;
    end
  end

  always_ff @(posedge clk) begin
    s2i_q <= slot_to_id[s2i_addr];
    if (cmd.alloc_commit) begin
      slot_to_id[count_idx] <= ring_val;
    end else if (cmd.rm_commit && moved) begin
      slot_to_id[i2s_q] <= s2i_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      wrapped <= 1'b0;
      count   <= '0;
    end else if (cmd.alloc_commit) begin
      head  <= (head == LastIdx) ? '0 : head + IW'(1);
      count <= count_inc;
    end else if (cmd.rm_commit) begin
      if (tail == LastIdx) begin
        tail    <= '0;
        wrapped <= 1'b1;
      end else begin
        tail <= tail + IW'(1);
      end
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.alloc_commit | cmd.rm_commit | cmd.emit_full | cmd.emit_dead;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      result.status       <= STATUS_OK;
      result.entity_out   <= ring_w[5:0];
      result.dense_slot   <= cnt_w[5:0];
      result.moved_entity <= '0;
      result.moved_valid  <= 1'b0;
      result.live_total   <= inc_w[6:0];
    end else if (cmd.rm_commit) begin
      result.status       <= STATUS_OK;
      result.entity_out   <= tgt;
      result.dense_slot   <= i2s_w[5:0];
      result.moved_entity <= moved ? s2i_w[5:0] : 6'd0;
      result.moved_valid  <= moved;
      result.live_total   <= dec_w[6:0];
    end else if (cmd.emit_full) begin
      result.status       <= STATUS_FULL;
      result.entity_out   <= '0;
      result.dense_slot   <= '0;
      result.moved_entity <= '0;
      result.moved_valid  <= 1'b0;
      result.live_total   <= cnt_w[6:0];
    end else if (cmd.emit_dead) begin
      result.status       <= STATUS_DEAD;
      result.entity_out   <= tgt;
      result.dense_slot   <= '0;
      result.moved_entity <= '0;
      result.moved_valid  <= 1'b0;
      result.live_total   <= cnt_w[6:0];
    end
  end

endmodule

// ----- rtl/core/entity_id_allocator_dense_map.sv -----
`timescale 1ns / 1ps

// Entity identifier allocator with a packed dense map. A word is taken when
// start is high and busy is low; its result appears on result for exactly one
// cycle with done high, and the receiver cannot hold it off, so it must take
// every result word in that cycle. An allocate keeps busy high through the
// decode and alloc states (decode only when every identifier is in use) and a
// remove through decode, lookup, check and commit (decode only when nothing
// is live, decode to check when the identifier is not live), so a new word is
// not taken until the last one is through; done rises in the same cycle that
// busy falls, which is also the first cycle a new start is taken. The remove
// steps follow the chain of registered reads through the slot tables:
// identifier to slot, the slot's owner for the liveness check, then the
// owner of the last slot. The free list comes up holding every identifier in
// order straight out of reset, with no clearing pass.
module entity_id_allocator_dense_map
  import eida_pkg::*;
#(
  parameter int MAX_IDS = DEFAULT_MAX_IDS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  op_word_t  op,
  output logic      done,
  output res_word_t result
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  eida_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  eida_datapath #(
    .MAX_IDS (MAX_IDS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

// ----- rtl/core/eida_checker.sv -----
`timescale 1ns / 1ps
`include "entity_id_allocator_dense_map_macros.svh"

module eida_checker
  import eida_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input op_word_t  op,
  input logic      done,
  input res_word_t result
);

  `EIDA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `EIDA_ASSERT_SAME(a_done_after_busy, done, $past(busy))
  `EIDA_ASSERT_SAME(a_fall_gives_done, $fell(busy) && !$past(rst), done)
  `EIDA_ASSERT_SAME(a_full_blank, done && (result.status == STATUS_FULL),
                    !result.moved_valid && (result.entity_out == 6'd0))

endmodule

bind entity_id_allocator_dense_map eida_checker u_eida_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .op     (op),
  .done   (done),
  .result (result)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import eida_pkg::*;

  localparam int NUM_IDS = DEFAULT_MAX_IDS;

  logic      clk;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  op_word_t  op = '0;
  logic      busy;
  logic      done;
  res_word_t result;

  entity_id_allocator_dense_map #(
    .MAX_IDS(NUM_IDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .done(done),
    .result(result)
  );

  // Expected state of the allocator.
  logic [5:0]         free_ids [NUM_IDS];
  logic [5:0]         free_rd;
  logic [5:0]         free_wr;
  logic [5:0]         slot_of [NUM_IDS];
  logic [5:0]         owner_of [NUM_IDS];
  logic [NUM_IDS-1:0] alive;
  logic [6:0]         alive_cnt;

  res_word_t pending_results[$];
  int        errors;
  int        idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_word_t apply_op(input op_word_t w);
    res_word_t  r;
    logic [5:0] id;
    logic [5:0] slot;
    logic [5:0] last_slot;
    r = '0;
    if (w.action == ACT_ALLOC) begin
      if (alive_cnt == NUM_IDS) begin
        r.status = STATUS_FULL;
      end else begin
        id = free_ids[free_rd];
        free_rd = free_rd + 6'd1;
        slot = alive_cnt[5:0];
        alive_cnt = alive_cnt + 7'd1;
        slot_of[id] = slot;
        owner_of[slot] = id;
        alive[id] = 1'b1;
        r.status = STATUS_OK;
        r.entity_out = id;
        r.dense_slot = slot;
      end
    end else begin
      r.entity_out = w.target_id;
      if (!alive[w.target_id]) begin
        r.status = STATUS_DEAD;
      end else begin
        slot = slot_of[w.target_id];
        last_slot = 6'(alive_cnt - 7'd1);
        if (slot != last_slot) begin
          id = owner_of[last_slot];
          owner_of[slot] = id;
          slot_of[id] = slot;
          r.moved_entity = id;
          r.moved_valid = 1'b1;
        end
        alive[w.target_id] = 1'b0;
        free_ids[free_wr] = w.target_id;
        free_wr = free_wr + 6'd1;
        alive_cnt = alive_cnt - 7'd1;
        r.status = STATUS_OK;
        r.dense_slot = slot;
      end
    end
    r.live_total = alive_cnt;
    return r;
  endfunction

  function automatic op_word_t make_alloc();
    op_word_t w;
    w.action = ACT_ALLOC;
    w.target_id = 6'($urandom_range(63));
    return w;
  endfunction

  function automatic op_word_t make_remove(input logic [5:0] id);
    op_word_t w;
    w.action = ACT_REMOVE;
    w.target_id = id;
    return w;
  endfunction

  // Allocates at the given percentage; otherwise mostly removes of live entities, with some removes of arbitrary ones.
  function automatic op_word_t make_random_op(input int alloc_pct);
    if ($urandom_range(99) < alloc_pct) return make_alloc();
    if (alive_cnt != 0 && $urandom_range(99) < 85)
      return make_remove(owner_of[6'($urandom_range(int'(alive_cnt) - 1))]);
    return make_remove(6'($urandom_range(63)));
  endfunction

  task automatic send_op(input op_word_t w);
    start <= 1'b1;
    op <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_op(w));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      op <= 7'($urandom_range(127));
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    res_word_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %p", $time, result);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 7'(want.status), 7'(result.status));
        check_field("entity_out", 7'(want.entity_out), 7'(result.entity_out));
        check_field("dense_slot", 7'(want.dense_slot), 7'(result.dense_slot));
        check_field("moved_entity", 7'(want.moved_entity), 7'(result.moved_entity));
        check_field("moved_valid", 7'(want.moved_valid), 7'(result.moved_valid));
        check_field("live_total", want.live_total, result.live_total);
      end
    end
  end

  // Removes on an empty map, removes of the last slot and of a middle slot,
  // repeated removes, and reuse of freed identifiers in FIFO order.
  task automatic test_directed();
    idle_pct = 0;
    send_op(make_remove(6'd0));
    send_op(make_remove(6'd63));
    repeat (4) send_op(make_alloc());
    send_op(make_remove(6'd63));
    send_op(make_alloc());
    send_op(make_remove(6'd4));
    send_op(make_remove(6'd0));
    send_op(make_remove(6'd0));
    repeat (3) send_op(make_alloc());
    send_op(make_remove(6'd2));
    send_op(make_remove(6'd1));
    send_op(make_remove(6'd3));
    wait_drained();
  endtask

  // Fills the map, allocates while full, then removes every live entity.
  task automatic test_fill_drain();
    idle_pct = 19;
    while (alive_cnt < NUM_IDS) send_op(make_alloc());
    repeat (2) send_op(make_alloc());
    send_op(make_remove(6'd63));
    send_op(make_remove(6'd0));
    repeat (3) send_op(make_alloc());
    while (alive_cnt != 0) begin
      send_op(make_remove(owner_of[6'($urandom_range(int'(alive_cnt) - 1))]));
      if ($urandom_range(99) < 10) send_op(make_remove(6'($urandom_range(63))));
    end
    send_op(make_remove(6'($urandom_range(63))));
    wait_drained();
  endtask

  task automatic test_random();
    int phase_idle [4] = '{0, 82, 0, 19};
    int alloc_mix [3] = '{30, 55, 85};
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < 75; i++) begin
        send_op(make_random_op(alloc_mix[(i / 25 + p) % 3]));
      end
      wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_IDS; i++) begin
      free_ids[i] = 6'(i);
      slot_of[i] = '0;
      owner_of[i] = '0;
    end
    free_rd = '0;
    free_wr = '0;
    alive = '0;
    alive_cnt = '0;
    errors = 0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_drain();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
